/* design/lav_pkg.sv */
// ----------------------------------------------------------------------------
// lav_pkg
// Shared constants for the look-at view matrix pipeline.
// ----------------------------------------------------------------------------
package lav_pkg;

   localparam int DATA_W        = 32;   // width of every port field
   localparam int COMP_N        = 3;    // vector components
   localparam int FRAC_BITS_DEF = 16;   // default fraction bits (Q16.16)
   localparam int NORM_W        = 31;   // normalized magnitude width, top in [2^30, 2^31)

endpackage

/* design/look_at_view_matrix_core.sv */
// ----------------------------------------------------------------------------
// look_at_view_matrix_core
// Fixed-point look-at view matrix: side, true up, back and translation row.
// ----------------------------------------------------------------------------
// One item on req_ describes a camera (eye, view direction, up hint); one item
// on rsp_ returns the varying view matrix entries for it, in input order.
// Dataflow: normalize direction -> f; cross f x up; normalize -> s;
// cross s x f; normalize -> u; dot products with the eye -> translations.
// Each normalizer is F+40 stages deep (bit-per-stage square root over the
// 64-bit sum of squares, then one quotient bit per stage for the divide);
// each cross product is 2 stages, the translation unit 3.
// Entries are Q16.16 at the default FRAC_BITS.
// Throughput: one item per cycle while the output does not stall; fully pipelined.
// The last translation stage is the output register. When rsp_tready is low
// with a result pending, the whole pipeline holds and req_tready drops; no
// item is lost or repeated. Reset clears all valid bits; nothing else needs
// it and the pipeline is ready the cycle after reset is released.
// ----------------------------------------------------------------------------
module look_at_view_matrix_core import lav_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // eye_x, eye_y, eye_z, view_dir_x, view_dir_y, view_dir_z,
   // up_hint_x, up_hint_y, up_hint_z (32 bits each, lowest first)
   input  logic [9*DATA_W-1:0]    req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // side_x, side_y, side_z, true_up_x, true_up_y, true_up_z,
   // back_x, back_y, back_z, shift_x, shift_y, shift_z (32 bits each)
   output logic [12*DATA_W-1:0]   rsp_tdata
);

   localparam int FW      = FRAC_BITS + 2;      // unit vector component
   localparam int T1_W    = FW + DATA_W + 1;    // f x up
   localparam int T2_W    = 2 * FW + 1;         // s x f
   localparam int V3_W    = COMP_N * DATA_W;
   localparam int F3_W    = COMP_N * FW;
   localparam int SIDE1_W = 2 * V3_W;           // eye, up
   localparam int SIDE2_W = V3_W + F3_W;        // eye, f
   localparam int SIDE3_W = V3_W + 2 * F3_W;    // eye, f, s

   // global advance: hold everything while a result waits
   logic en;
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   logic signed [DATA_W-1:0] dir_c [COMP_N];
   logic [SIDE1_W-1:0]       side1_in;

   always_comb begin
      for (int i = 0; i < COMP_N; i++) begin
         dir_c[i] = req_tdata[(COMP_N+i)*DATA_W +: DATA_W];
      end
      side1_in = {req_tdata[3*V3_W-1:2*V3_W], req_tdata[V3_W-1:0]};
   end

   // normalize direction -> f
   logic                     v1;
   logic signed [FW-1:0]     f1 [COMP_N];
   logic [SIDE1_W-1:0]       side1_out;

   lav_unit_vec #(.IN_W(DATA_W), .FRAC_BITS(FRAC_BITS), .SIDE_W(SIDE1_W)) u_norm_fwd (
      .clock, .reset, .en,
      .vld_in(req_tvalid && en), .vec_in(dir_c), .side_in(side1_in),
      .vld_out(v1), .unit_out(f1), .side_out(side1_out)
   );

   // f x up
   logic signed [DATA_W-1:0] up1 [COMP_N];
   logic [SIDE2_W-1:0]       side2_in, side2_out;
   logic                     v2;
   logic signed [T1_W-1:0]   t1 [COMP_N];

   always_comb begin
      for (int i = 0; i < COMP_N; i++) begin
         up1[i] = side1_out[V3_W + i*DATA_W +: DATA_W];
         side2_in[V3_W + i*FW +: FW] = f1[i];
      end
      side2_in[V3_W-1:0] = side1_out[V3_W-1:0];
   end

   lav_cross #(.A_W(FW), .B_W(DATA_W), .SIDE_W(SIDE2_W)) u_cross_side (
      .clock, .reset, .en,
      .vld_in(v1), .a_in(f1), .b_in(up1), .side_in(side2_in),
      .vld_out(v2), .cross_out(t1), .side_out(side2_out)
   );

   // normalize -> s
   logic                 v3;
   logic signed [FW-1:0] s3 [COMP_N];
   logic [SIDE2_W-1:0]   side3_out;

   lav_unit_vec #(.IN_W(T1_W), .FRAC_BITS(FRAC_BITS), .SIDE_W(SIDE2_W)) u_norm_side (
      .clock, .reset, .en,
      .vld_in(v2), .vec_in(t1), .side_in(side2_out),
      .vld_out(v3), .unit_out(s3), .side_out(side3_out)
   );

   // s x f
   logic signed [FW-1:0]   f3 [COMP_N];
   logic [SIDE3_W-1:0]     side4_in, side4_out;
   logic                   v4;
   logic signed [T2_W-1:0] t2 [COMP_N];

   always_comb begin
      for (int i = 0; i < COMP_N; i++) begin
         f3[i] = side3_out[V3_W + i*FW +: FW];
         side4_in[V3_W + F3_W + i*FW +: FW] = s3[i];
      end
      side4_in[SIDE2_W-1:0] = side3_out;
   end

   lav_cross #(.A_W(FW), .B_W(FW), .SIDE_W(SIDE3_W)) u_cross_up (
      .clock, .reset, .en,
      .vld_in(v3), .a_in(s3), .b_in(f3), .side_in(side4_in),
      .vld_out(v4), .cross_out(t2), .side_out(side4_out)
   );

   // normalize -> u
   logic                 v5;
   logic signed [FW-1:0] u5 [COMP_N];
   logic [SIDE3_W-1:0]   side5_out;

   lav_unit_vec #(.IN_W(T2_W), .FRAC_BITS(FRAC_BITS), .SIDE_W(SIDE3_W)) u_norm_up (
      .clock, .reset, .en,
      .vld_in(v4), .vec_in(t2), .side_in(side4_out),
      .vld_out(v5), .unit_out(u5), .side_out(side5_out)
   );

   // translations and output register
   logic signed [DATA_W-1:0] eye5 [COMP_N];
   logic signed [FW-1:0]     f5 [COMP_N], s5 [COMP_N];
   logic signed [DATA_W-1:0] side_o [COMP_N], up_o [COMP_N];
   logic signed [DATA_W-1:0] back_o [COMP_N], shift_o [COMP_N];

   always_comb begin
      for (int i = 0; i < COMP_N; i++) begin
         eye5[i] = side5_out[i*DATA_W +: DATA_W];
         f5[i]   = side5_out[V3_W + i*FW +: FW];
         s5[i]   = side5_out[V3_W + F3_W + i*FW +: FW];
      end
   end

   lav_xlate #(.FRAC_BITS(FRAC_BITS)) u_xlate (
      .clock, .reset, .en,
      .vld_in(v5), .side_in(s5), .up_in(u5), .fwd_in(f5), .eye_in(eye5),
      .vld_out(rsp_tvalid), .side_out(side_o), .up_out(up_o),
      .back_out(back_o), .shift_out(shift_o)
   );

   always_comb begin
      for (int i = 0; i < COMP_N; i++) begin
         rsp_tdata[i*DATA_W +: DATA_W]            = side_o[i];
         rsp_tdata[(COMP_N+i)*DATA_W +: DATA_W]   = up_o[i];
         rsp_tdata[(2*COMP_N+i)*DATA_W +: DATA_W] = back_o[i];
         rsp_tdata[(3*COMP_N+i)*DATA_W +: DATA_W] = shift_o[i];
      end
   end

endmodule

/* design/lav_unit_vec.sv */
// ----------------------------------------------------------------------------
// lav_unit_vec
// Pipelined vector normalizer: scale, sum of squares, bit-per-stage square
// root, bit-per-stage rounded divide. Carries a side word in lock step.
// ----------------------------------------------------------------------------
module lav_unit_vec import lav_pkg::*; #(
   parameter int IN_W      = 32,
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int SIDE_W    = 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       vld_in,
   input  logic signed [IN_W-1:0]     vec_in [COMP_N],
   input  logic [SIDE_W-1:0]          side_in,
   output logic                       vld_out,
   output logic signed [FRAC_BITS+1:0] unit_out [COMP_N],
   output logic [SIDE_W-1:0]          side_out
);

   localparam int PW         = $clog2(IN_W);
   localparam int SQ_W       = 2 * NORM_W;
   localparam int SUM_W      = SQ_W + 2;
   localparam int ROOT_STEPS = SUM_W / 2;
   localparam int LEN_W      = ROOT_STEPS;
   localparam int REM_W      = LEN_W + FRAC_BITS + 1;
   localparam int Q_W        = FRAC_BITS + 1;
   localparam int OUT_W      = FRAC_BITS + 2;
   localparam int DIV_STEPS  = Q_W;
   localparam int LAT        = 5 + ROOT_STEPS + 1 + DIV_STEPS + 1;

   // stage 1: magnitudes and largest one
   logic [IN_W-1:0]   mag_c  [COMP_N];
   logic [COMP_N-1:0] neg_c;
   logic [IN_W-1:0]   max_c;
   logic [IN_W-1:0]   mag1_ff [COMP_N];
   logic [COMP_N-1:0] neg1_ff;
   logic [IN_W-1:0]   max1_ff;

   always_comb begin
      for (int i = 0; i < COMP_N; i++) begin
         neg_c[i] = vec_in[i][IN_W-1];
         mag_c[i] = neg_c[i] ? IN_W'(-vec_in[i]) : IN_W'(vec_in[i]);
      end
      max_c = mag_c[0];
      for (int i = 1; i < COMP_N; i++) begin
         if (mag_c[i] > max_c) max_c = mag_c[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag1_ff <= mag_c;
         neg1_ff <= neg_c;
         max1_ff <= max_c;
      end
   end

   // stage 2: leading one of the largest magnitude
   logic [PW-1:0]     pos_c;
   logic [IN_W-1:0]   mag2_ff [COMP_N];
   logic [COMP_N-1:0] neg2_ff;
   logic [PW-1:0]     pos2_ff;
   logic              zero2_ff;

   always_comb begin
      pos_c = '0;
      for (int b = 0; b < IN_W; b++) begin
         if (max1_ff[b]) pos_c = PW'(b);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag2_ff  <= mag1_ff;
         neg2_ff  <= neg1_ff;
         pos2_ff  <= pos_c;
         zero2_ff <= (max1_ff == '0);
      end
   end

   // stage 3: shift so the leading one lands on bit NORM_W-1
   logic [IN_W+NORM_W-2:0] ext_c [COMP_N];
   logic [NORM_W-1:0]      sm_c  [COMP_N];
   logic [NORM_W-1:0]      sm3_ff [COMP_N];
   logic [COMP_N-1:0]      neg3_ff;
   logic                   zero3_ff;

   always_comb begin
      for (int i = 0; i < COMP_N; i++) begin
         ext_c[i] = {mag2_ff[i], (NORM_W-1)'(0)} >> pos2_ff;
         sm_c[i]  = ext_c[i][NORM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sm3_ff   <= sm_c;
         neg3_ff  <= neg2_ff;
         zero3_ff <= zero2_ff;
      end
   end

   // stage 4: squares
   logic [SQ_W-1:0]   sq4_ff [COMP_N];
   logic [NORM_W-1:0] sm4_ff [COMP_N];
   logic [COMP_N-1:0] neg4_ff;
   logic              zero4_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < COMP_N; i++) begin
            sq4_ff[i] <= sm3_ff[i] * sm3_ff[i];
         end
         sm4_ff   <= sm3_ff;
         neg4_ff  <= neg3_ff;
         zero4_ff <= zero3_ff;
      end
   end

   // stage 5 feeds the root chain: index 0 holds the sum of squares
   logic [SUM_W-1:0]  rn_ff   [ROOT_STEPS+1];
   logic [SUM_W-1:0]  rr_ff   [ROOT_STEPS+1];
   logic [NORM_W-1:0] rsm_ff  [ROOT_STEPS+1][COMP_N];
   logic [COMP_N-1:0] rneg_ff [ROOT_STEPS+1];
   logic              rzero_ff [ROOT_STEPS+1];

   always_ff @(posedge clock) begin
      if (en) begin
         rn_ff[0]    <= SUM_W'(sq4_ff[0]) + SUM_W'(sq4_ff[1]) + SUM_W'(sq4_ff[2]);
         rr_ff[0]    <= '0;
         rsm_ff[0]   <= sm4_ff;
         rneg_ff[0]  <= neg4_ff;
         rzero_ff[0] <= zero4_ff;
      end
   end

   // integer square root, one result bit per stage
   for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
      localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (SUM_W - 2 - 2 * k);
      logic [SUM_W-1:0] trial;
      logic             ge;

      assign trial = rr_ff[k] + BIT;
      assign ge    = (rn_ff[k] >= trial);

      always_ff @(posedge clock) begin
         if (en) begin
            rn_ff[k+1]    <= ge ? rn_ff[k] - trial : rn_ff[k];
            rr_ff[k+1]    <= ge ? (rr_ff[k] >> 1) + BIT : rr_ff[k] >> 1;
            rsm_ff[k+1]   <= rsm_ff[k];
            rneg_ff[k+1]  <= rneg_ff[k];
            rzero_ff[k+1] <= rzero_ff[k];
         end
      end
   end

   // divide setup: numerator = mag * 2^F + len / 2
   logic [REM_W-1:0]  drem_ff  [DIV_STEPS+1][COMP_N];
   logic [Q_W-1:0]    dq_ff    [DIV_STEPS+1][COMP_N];
   logic [LEN_W-1:0]  dlen_ff  [DIV_STEPS+1];
   logic [COMP_N-1:0] dneg_ff  [DIV_STEPS+1];
   logic              dzero_ff [DIV_STEPS+1];
   logic [LEN_W-1:0]  len_c;

   assign len_c = rr_ff[ROOT_STEPS][LEN_W-1:0];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < COMP_N; i++) begin
            drem_ff[0][i] <= REM_W'({rsm_ff[ROOT_STEPS][i], FRAC_BITS'(0)})
                           + REM_W'(len_c >> 1);
            dq_ff[0][i]   <= '0;
         end
         dlen_ff[0]  <= len_c;
         dneg_ff[0]  <= rneg_ff[ROOT_STEPS];
         dzero_ff[0] <= rzero_ff[ROOT_STEPS];
      end
   end

   // restoring divide, one quotient bit per stage, MSB first
   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      localparam int B = DIV_STEPS - 1 - j;
      logic [REM_W-1:0]  dvs;
      logic [COMP_N-1:0] ge;

      assign dvs = REM_W'(dlen_ff[j]) << B;

      always_comb begin
         for (int i = 0; i < COMP_N; i++) begin
            ge[i] = (drem_ff[j][i] >= dvs);
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            for (int i = 0; i < COMP_N; i++) begin
               drem_ff[j+1][i] <= ge[i] ? drem_ff[j][i] - dvs : drem_ff[j][i];
               dq_ff[j+1][i]   <= dq_ff[j][i] | (Q_W'(ge[i]) << B);
            end
            dlen_ff[j+1]  <= dlen_ff[j];
            dneg_ff[j+1]  <= dneg_ff[j];
            dzero_ff[j+1] <= dzero_ff[j];
         end
      end
   end

   // sign restore; zero-length vector gives zero
   logic signed [OUT_W-1:0] unit_ff [COMP_N];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < COMP_N; i++) begin
            if (dzero_ff[DIV_STEPS]) begin
               unit_ff[i] <= '0;
            end else if (dneg_ff[DIV_STEPS][i]) begin
               unit_ff[i] <= -OUT_W'(dq_ff[DIV_STEPS][i]);
            end else begin
               unit_ff[i] <= OUT_W'(dq_ff[DIV_STEPS][i]);
            end
         end
      end
   end

   assign unit_out = unit_ff;

   // valid and side word in lock step with the datapath
   logic [LAT-1:0]    vld_ff;
   logic [SIDE_W-1:0] side_ff [LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], vld_in};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         for (int k = 1; k < LAT; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign vld_out  = vld_ff[LAT-1];
   assign side_out = side_ff[LAT-1];

endmodule

/* design/lav_cross.sv */
// ----------------------------------------------------------------------------
// lav_cross
// Two-stage cross product a x b: products, then differences.
// ----------------------------------------------------------------------------
module lav_cross import lav_pkg::*; #(
   parameter int A_W    = 18,
   parameter int B_W    = 32,
   parameter int SIDE_W = 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       vld_in,
   input  logic signed [A_W-1:0]      a_in [COMP_N],
   input  logic signed [B_W-1:0]      b_in [COMP_N],
   input  logic [SIDE_W-1:0]          side_in,
   output logic                       vld_out,
   output logic signed [A_W+B_W:0]    cross_out [COMP_N],
   output logic [SIDE_W-1:0]          side_out
);

   localparam int PROD_W = A_W + B_W;

   logic signed [PROD_W-1:0] prod_ff [2*COMP_N];
   logic signed [PROD_W:0]   cross_ff [COMP_N];
   logic [SIDE_W-1:0]        side1_ff, side2_ff;
   logic                     vld1_ff, vld2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff[0] <= a_in[1] * b_in[2];
         prod_ff[1] <= b_in[1] * a_in[2];
         prod_ff[2] <= a_in[2] * b_in[0];
         prod_ff[3] <= b_in[2] * a_in[0];
         prod_ff[4] <= a_in[0] * b_in[1];
         prod_ff[5] <= b_in[0] * a_in[1];
         side1_ff   <= side_in;
         for (int i = 0; i < COMP_N; i++) begin
            cross_ff[i] <= (PROD_W+1)'(prod_ff[2*i]) - (PROD_W+1)'(prod_ff[2*i+1]);
         end
         side2_ff   <= side1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else if (en) begin
         vld1_ff <= vld_in;
         vld2_ff <= vld1_ff;
      end
   end

   assign vld_out   = vld2_ff;
   assign cross_out = cross_ff;
   assign side_out  = side2_ff;

endmodule

/* design/lav_xlate.sv */
// ----------------------------------------------------------------------------
// lav_xlate
// Translation row: three dot products with the eye, rounded and saturated,
// plus final packing of the rotation entries.
// ----------------------------------------------------------------------------
module lav_xlate import lav_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        vld_in,
   input  logic signed [FRAC_BITS+1:0] side_in [COMP_N],
   input  logic signed [FRAC_BITS+1:0] up_in   [COMP_N],
   input  logic signed [FRAC_BITS+1:0] fwd_in  [COMP_N],
   input  logic signed [DATA_W-1:0]    eye_in  [COMP_N],
   output logic                        vld_out,
   output logic signed [DATA_W-1:0]    side_out  [COMP_N],
   output logic signed [DATA_W-1:0]    up_out    [COMP_N],
   output logic signed [DATA_W-1:0]    back_out  [COMP_N],
   output logic signed [DATA_W-1:0]    shift_out [COMP_N]
);

   localparam int FW     = FRAC_BITS + 2;
   localparam int PROD_W = FW + DATA_W;
   localparam int DOT_W  = PROD_W + 3;
   localparam int R_W    = DOT_W - FRAC_BITS;
   localparam int LANE_FWD = 2;   // forward lane keeps its sign
   localparam logic signed [DOT_W-1:0] HALF = DOT_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   logic signed [PROD_W-1:0] prod_ff [COMP_N][COMP_N];
   logic signed [DOT_W-1:0]  dot_ff  [COMP_N];
   logic signed [FW-1:0]     s1_ff [COMP_N], u1_ff [COMP_N], f1_ff [COMP_N];
   logic signed [FW-1:0]     s2_ff [COMP_N], u2_ff [COMP_N], f2_ff [COMP_N];
   logic [2:0]               vld_ff;

   // stage 1: products
   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < COMP_N; c++) begin
            prod_ff[0][c] <= side_in[c] * eye_in[c];
            prod_ff[1][c] <= up_in[c] * eye_in[c];
            prod_ff[2][c] <= fwd_in[c] * eye_in[c];
         end
         s1_ff <= side_in;
         u1_ff <= up_in;
         f1_ff <= fwd_in;
      end
   end

   // stage 2: sums
   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < COMP_N; l++) begin
            dot_ff[l] <= DOT_W'(prod_ff[l][0]) + DOT_W'(prod_ff[l][1])
                       + DOT_W'(prod_ff[l][2]);
         end
         s2_ff <= s1_ff;
         u2_ff <= u1_ff;
         f2_ff <= f1_ff;
      end
   end

   // stage 3: sign, round half up, saturate
   logic signed [DOT_W-1:0] t_c   [COMP_N];
   logic signed [R_W-1:0]   rnd_c [COMP_N];
   logic signed [DATA_W-1:0] sat_c [COMP_N];

   always_comb begin
      for (int l = 0; l < COMP_N; l++) begin
         t_c[l]   = ((l == LANE_FWD) ? dot_ff[l] : -dot_ff[l]) + HALF;
         rnd_c[l] = t_c[l][DOT_W-1:FRAC_BITS];
         if ((&rnd_c[l][R_W-1:DATA_W-1]) || !(|rnd_c[l][R_W-1:DATA_W-1])) begin
            sat_c[l] = rnd_c[l][DATA_W-1:0];
         end else if (rnd_c[l][R_W-1]) begin
            sat_c[l] = SAT_MIN;
         end else begin
            sat_c[l] = SAT_MAX;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < COMP_N; c++) begin
            side_out[c] <= DATA_W'(s2_ff[c]);
            up_out[c]   <= DATA_W'(u2_ff[c]);
            back_out[c] <= -DATA_W'(f2_ff[c]);
         end
         shift_out <= sat_c;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[1:0], vld_in};
      end
   end

   assign vld_out = vld_ff[2];

endmodule

/* test/look_at_view_matrix_core_test.sv */
// ----------------------------------------------------------------------------
// look_at_view_matrix_core_test
// Self-checking bench for the fixed-point look-at view matrix core.
// ----------------------------------------------------------------------------
// Camera items go in on req_, view matrix entries come back on rsp_. A local
// model in SystemVerilog predicts every entry; results are compared in order.
// Directed cameras cover extreme fields, zero and parallel vectors and
// translation saturation; random cameras follow under four idling phases.
// ----------------------------------------------------------------------------
module look_at_view_matrix_core_test import lav_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FB      = FRAC_BITS_DEF;
   localparam int LATENCY = 3 * FB + 127;

   typedef logic signed [DATA_W-1:0] fix_type;
   typedef logic signed [63:0]       wide_type;

   typedef struct packed {
      fix_type up_z, up_y, up_x, dir_z, dir_y, dir_x, eye_z, eye_y, eye_x;
   } camera_type;

   typedef struct packed {
      fix_type shift_z, shift_y, shift_x, back_z, back_y, back_x;
      fix_type up_z, up_y, up_x, side_z, side_y, side_x;
   } view_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [9*DATA_W-1:0]  req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [12*DATA_W-1:0] rsp_tdata;

   view_type views_due[$];
   int    mismatches = 0;
   int    views_seen = 0;
   int    cams_sent  = 0;
   int    send_gap   = 0;  // percent idle on the sender
   int    stall_pct  = 0;  // percent stall on the receiver

   look_at_view_matrix_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------
   function automatic logic [63:0] int_sqrt(logic [63:0] n);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // scale so the biggest magnitude sits in [2^30, 2^31), then divide by length
   function automatic void normalize(input wide_type v[3], output wide_type o[3]);
      logic [63:0] mag[3], m, sq, len, q;
      logic        neg[3];
      m = 0;
      for (int i = 0; i < 3; i++) begin
         neg[i] = v[i] < 0;
         mag[i] = neg[i] ? -v[i] : v[i];
         if (mag[i] > m) m = mag[i];
      end
      if (m == 0) begin
         for (int i = 0; i < 3; i++) o[i] = 0;
         return;
      end
      while (m >= (64'd1 << 31)) begin
         m = m >> 1;
         for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
      end
      while (m < (64'd1 << 30)) begin
         m = m << 1;
         for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
      end
      sq = 0;
      for (int i = 0; i < 3; i++) sq = sq + mag[i] * mag[i];
      len = int_sqrt(sq);
      for (int i = 0; i < 3; i++) begin
         q = ((mag[i] << FB) + (len >> 1)) / len;
         o[i] = neg[i] ? -wide_type'(q) : wide_type'(q);
      end
   endfunction

   function automatic void cross3(input wide_type a[3], input wide_type b[3],
                                  output wide_type o[3]);
      o[0] = a[1] * b[2] - b[1] * a[2];
      o[1] = a[2] * b[0] - b[2] * a[0];
      o[2] = a[0] * b[1] - b[0] * a[1];
   endfunction

   // add half an LSB, floor, saturate to 32 bits
   function automatic fix_type round_clamp(wide_type x);
      wide_type t, r;
      t = x + (wide_type'(1) << (FB - 1));
      r = t >>> FB;
      if (r > 64'sh7FFF_FFFF) r = 64'sh7FFF_FFFF;
      if (r < -64'sh8000_0000) r = -64'sh8000_0000;
      return fix_type'(r);
   endfunction

   function automatic view_type view_of(camera_type c);
      wide_type eye[3], dir[3], up[3], f[3], s[3], u[3], t[3];
      view_type v;
      eye = '{c.eye_x, c.eye_y, c.eye_z};
      dir = '{c.dir_x, c.dir_y, c.dir_z};
      up  = '{c.up_x, c.up_y, c.up_z};
      normalize(dir, f);
      cross3(f, up, t);
      normalize(t, s);
      cross3(s, f, t);
      normalize(t, u);
      v.side_x = fix_type'(s[0]); v.side_y = fix_type'(s[1]); v.side_z = fix_type'(s[2]);
      v.up_x   = fix_type'(u[0]); v.up_y   = fix_type'(u[1]); v.up_z   = fix_type'(u[2]);
      v.back_x = fix_type'(-f[0]); v.back_y = fix_type'(-f[1]); v.back_z = fix_type'(-f[2]);
      v.shift_x = round_clamp(-(s[0] * eye[0] + s[1] * eye[1] + s[2] * eye[2]));
      v.shift_y = round_clamp(-(u[0] * eye[0] + u[1] * eye[1] + u[2] * eye[2]));
      v.shift_z = round_clamp(f[0] * eye[0] + f[1] * eye[1] + f[2] * eye[2]);
      return v;
   endfunction

   // ------------------------------------------------------------------
   // Sender: one camera item, random idle before it per send_gap
   // ------------------------------------------------------------------
   task automatic send_camera(camera_type c);
      while ($urandom_range(99) < send_gap) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      views_due.push_back(view_of(c));
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      cams_sent++;
   endtask

   // receiver stall pattern, redrawn every edge
   always @(posedge clock) begin
      if (!reset) rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // result checker
   always @(posedge clock) begin
      view_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         views_seen++;
         if (views_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
         end else begin
            want = views_due.pop_front();
            for (int k = 0; k < 12; k++) begin
               if (got[k*DATA_W +: DATA_W] !== want[k*DATA_W +: DATA_W]) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("result %0d entry %0d: expected %h got %h", views_seen, k,
                              want[k*DATA_W +: DATA_W], got[k*DATA_W +: DATA_W]);
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Test tasks
   // ------------------------------------------------------------------
   function automatic camera_type cam(fix_type ex, fix_type ey, fix_type ez, fix_type dx,
                                      fix_type dy, fix_type dz, fix_type ux, fix_type uy,
                                      fix_type uz);
      camera_type c;
      c.eye_x = ex; c.eye_y = ey; c.eye_z = ez;
      c.dir_x = dx; c.dir_y = dy; c.dir_z = dz;
      c.up_x = ux; c.up_y = uy; c.up_z = uz;
      return c;
   endfunction

   task automatic test_directed();
      localparam fix_type ONE = 32'sh0001_0000;
      localparam fix_type MAXV = 32'sh7FFF_FFFF;
      localparam fix_type MINV = 32'sh8000_0000;
      // standard camera, zero direction, zero up, up parallel to direction
      send_camera(cam(0, 0, 5*ONE, 0, 0, -ONE, 0, ONE, 0));
      send_camera(cam(ONE, 2*ONE, 3*ONE, 0, 0, 0, 0, ONE, 0));
      send_camera(cam(ONE, 2*ONE, 3*ONE, ONE, 0, 0, 0, 0, 0));
      send_camera(cam(ONE, 2*ONE, 3*ONE, 0, 3*ONE, 0, 0, -7*ONE, 0));
      // extremes of every field, saturating translations
      send_camera(cam(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MINV, MAXV, MINV));
      send_camera(cam(MINV, MINV, MINV, MINV, MINV, MINV, MAXV, MINV, MAXV));
      send_camera(cam(MAXV, MINV, MAXV, ONE, ONE, 0, 0, 0, ONE));
      send_camera(cam(MINV, MAXV, MINV, -ONE, -ONE, 0, 0, 0, ONE));
      send_camera(cam(-1, -1, -1, 1, 0, 0, 0, 1, 0));
      send_camera(cam(1, 1, 1, 0, -1, 0, 0, 0, -1));
      send_camera(cam(MAXV, 0, 0, MINV, 1, 0, MAXV, MAXV, 0));
      send_camera(cam(-32768, 32768, 32767, 3, 4, 12, -5, 7, 1));
      send_camera(cam(0, 0, 0, ONE, 2*ONE, 2*ONE, -ONE, ONE, 0));
   endtask

   function automatic fix_type rand_field();
      case ($urandom_range(3))
         0: return fix_type'($urandom);
         1: return fix_type'($signed($urandom_range(16*65536)) - 8*65536);
         2: return fix_type'($signed($urandom_range(200)) - 100);
         default: return fix_type'($urandom) >>> $urandom_range(31);
      endcase
   endfunction

   task automatic test_random(int count, int gap, int stall);
      camera_type c;
      send_gap  = gap;
      stall_pct = stall;
      for (int n = 0; n < count; n++) begin
         c = {rand_field(), rand_field(), rand_field(), rand_field(), rand_field(),
              rand_field(), rand_field(), rand_field(), rand_field()};
         // now and then make the up hint parallel to the direction
         if ($urandom_range(19) == 0) begin
            c.up_x = c.dir_x >>> 1; c.up_y = c.dir_y >>> 1; c.up_z = c.dir_z >>> 1;
         end
         send_camera(c);
      end
   endtask

   task automatic drain();
      int waited;
      waited = 0;
      req_tvalid <= 1'b0;
      while (views_due.size() != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      stall_pct = 0;
      test_directed();
      test_random(240, 0, 0);
      test_random(230, 51, 0);
      test_random(230, 0, 51);
      test_random(240, 27, 27);
      stall_pct = 0;
      drain();
      $display("Sent %0d camera items (directed and random over four idling phases),",
               cams_sent);
      $display("checked %0d view matrix results, %0d mismatching entries.",
               views_seen, mismatches);
      if (mismatches == 0 && views_due.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
